// ===== src/rau_pkg.sv =====
`default_nettype none
package rau_pkg;
  localparam int OperandWidthDef = 32;
  localparam int ResW = 64;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_GCD,
    BK_DIVN,
    BK_DIVD,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  status;
    logic [31:0] a_num;
    logic [30:0] a_den;
    logic [31:0] b_num;
    logic [30:0] b_den;
  } job_t;
endpackage
`default_nettype wire

// ===== src/rau_front.sv =====
`default_nettype none
module rau_front import rau_pkg::*; #(
  parameter int OperandWidth = OperandWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_a_num,
  input  wire logic [30:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [30:0] in_b_den,
  output logic             q_valid,
  input  wire logic        q_ready,
  output job_t             q_job
);
  localparam int Depth = 2;
  job_t        mem_r [Depth];
  logic        wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  job_t        job;
  logic [31:0] an, bn;
  logic [30:0] ad, bd;
  logic        push, pop;

  assign an = {{(32-OperandWidth){in_a_num[OperandWidth-1]}}, in_a_num[OperandWidth-1:0]};
  assign bn = {{(32-OperandWidth){in_b_num[OperandWidth-1]}}, in_b_num[OperandWidth-1:0]};
  assign ad = {{(32-OperandWidth){1'b0}}, in_a_den[OperandWidth-2:0]};
  assign bd = {{(32-OperandWidth){1'b0}}, in_b_den[OperandWidth-2:0]};

  always_comb begin
    job.action = in_action;
    job.a_num  = an;
    job.a_den  = ad;
    job.b_num  = bn;
    job.b_den  = bd;
    if (ad == '0 || bd == '0) begin
      job.status = ST_ZDEN;
    end else if (in_action == ACT_DIV && bn == '0) begin
      job.status = ST_DIV0;
    end else begin
      job.status = ST_OK;
    end
  end

  assign in_ready = (cnt_r != 2'(Depth));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_job    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign wp_nxt   = push ? ~wp_r : wp_r;
  assign rp_nxt   = pop ? ~rp_r : rp_r;
  assign cnt_nxt  = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(Depth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) push && !pop |=> cnt_r != 2'd0)
    else $error("queue lost entry");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'(Depth)) |-> !in_ready)
    else $error("accept while full");
endmodule
`default_nettype wire

// ===== src/rau_divider.sv =====
`default_nettype none
module rau_divider import rau_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [ResW-1:0] dividend,
  input  wire logic [ResW-1:0] divisor,
  output logic                 done,
  output logic [ResW-1:0]      quot,
  output logic [ResW-1:0]      rem
);
  logic [ResW-1:0] q_r, q_nxt, r_r, r_nxt, d_r;
  logic [6:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [ResW:0]   trial;

  assign trial = {r_r, q_r[ResW-1]} - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      cnt_nxt  = 7'(ResW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[ResW]) begin
        r_nxt = trial[ResW-1:0];
        q_nxt = {q_r[ResW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[ResW-2:0], q_r[ResW-1]};
        q_nxt = {q_r[ResW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done   <= busy_r && cnt_r == 7'd1;
    end
  end

  assign quot = q_r;
  assign rem  = r_r;
endmodule
`default_nettype wire

// ===== src/rau_back.sv =====
`default_nettype none
module rau_back import rau_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire job_t        q_job,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_res_num,
  output logic [62:0]      out_res_den,
  output logic             out_is_less,
  output logic             out_is_equal,
  output logic [1:0]       out_status
);
  bk_state_t st_r, st_nxt;
  job_t        job_r;
  logic signed [63:0] p0_r, p1_r, p2_r, n_r;
  logic [63:0] nm_r, dm_r, x_r, y_r, g_r;
  logic        neg_r;
  logic        dv_start, dv_done;
  logic [63:0] dv_a, dv_b, dv_q, dv_r;
  logic        dv_busy_r;
  logic signed [63:0] an, bn, ad, bd, dsum;
  logic        take;

  assign an = 64'(signed'(job_r.a_num));
  assign bn = 64'(signed'(job_r.b_num));
  assign ad = {33'd0, job_r.a_den};
  assign bd = {33'd0, job_r.b_den};

  rau_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (q_valid) st_nxt = BK_MUL;
      BK_MUL: begin
        if (job_r.status != ST_OK || job_r.action > ACT_CMP) st_nxt = BK_OUT;
        else st_nxt = BK_SUM;
      end
      BK_SUM: begin
        if (job_r.action == ACT_CMP) st_nxt = BK_OUT;
        else st_nxt = BK_GCD;
      end
      BK_GCD: if (y_r == '0 && !dv_busy_r) st_nxt = BK_DIVN;
      BK_DIVN: if (dv_done) st_nxt = BK_DIVD;
      BK_DIVD: if (dv_done) st_nxt = BK_OUT;
      BK_OUT: if (out_ready) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready  = (st_r == BK_IDLE);
    take     = q_ready && q_valid;
    dv_start = 1'b0;
    dv_a     = x_r;
    dv_b     = y_r;
    case (st_r)
      BK_GCD: dv_start = (y_r != '0) && !dv_busy_r;
      BK_DIVN: begin
        dv_a = nm_r;
        dv_b = g_r;
        dv_start = !dv_busy_r && !dv_done;
      end
      BK_DIVD: begin
        dv_a = dm_r;
        dv_b = g_r;
        dv_start = !dv_busy_r && !dv_done;
      end
      default: ;
    endcase
  end

  assign dsum = (job_r.action == ACT_SUB) ? p0_r - p1_r :
                (job_r.action == ACT_MUL) ? p2_r : p0_r + p1_r;

  always_ff @(posedge clk) begin
    if (take) job_r <= q_job;
    case (st_r)
      BK_MUL: begin
        p0_r <= an * bd;
        p1_r <= bn * ad;
        p2_r <= an * bn;
        n_r  <= (job_r.action == ACT_DIV) ? ad * bn : ad * bd;
      end
      BK_SUM: begin
        if (job_r.action == ACT_DIV) begin
          neg_r <= p0_r[63] ^ n_r[63];
          nm_r  <= p0_r[63] ? -p0_r : p0_r;
          x_r   <= p0_r[63] ? -p0_r : p0_r;
        end else begin
          neg_r <= dsum[63];
          nm_r  <= dsum[63] ? -dsum : dsum;
          x_r   <= dsum[63] ? -dsum : dsum;
        end
        dm_r <= n_r[63] ? -n_r : n_r;
        y_r  <= n_r[63] ? -n_r : n_r;
      end
      BK_GCD: begin
        if (dv_done) begin
          x_r <= y_r;
          y_r <= dv_r;
        end
        g_r <= x_r;
      end
      BK_DIVN: if (dv_done) nm_r <= dv_q;
      BK_DIVD: if (dv_done) dm_r <= dv_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      dv_busy_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (dv_start) dv_busy_r <= 1'b1;
      else if (dv_done) dv_busy_r <= 1'b0;
    end
  end

  always_comb begin
    out_valid    = (st_r == BK_OUT);
    out_res_num  = '0;
    out_res_den  = '0;
    out_is_less  = 1'b0;
    out_is_equal = 1'b0;
    out_status   = job_r.status;
    if (job_r.status == ST_OK) begin
      if (job_r.action == ACT_CMP) begin
        out_is_less  = p0_r < p1_r;
        out_is_equal = p0_r == p1_r;
      end else if (job_r.action <= ACT_DIV) begin
        out_res_num = (neg_r && nm_r != '0) ? -nm_r : nm_r;
        out_res_den = dm_r[62:0];
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !q_ready)
    else $error("back accepts while result pending");
  assert property (@(posedge clk) disable iff (!rst_n) dv_start |-> !dv_busy_r)
    else $error("divider restarted while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && job_r.action <= ACT_DIV |-> out_res_den != '0)
    else $error("zero denominator on ok result");
endmodule
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
// Work: gcd takes one divider pass per Euclid step, plus two passes to
// reduce numerator and denominator; compare, unused codes and rejected
// requests bypass the divider.
// Throughput: one request at a time in the back end, set by the shared
// 64-bit radix-2 divider; a two-entry queue decouples input acceptance.
// Reset: rst_n synchronous, active low; clears queue and control state.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OperandWidthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_a_num,
  input  wire logic [30:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [30:0] in_b_den,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_res_num,
  output logic [62:0]      out_res_den,
  output logic             out_is_less,
  output logic             out_is_equal,
  output logic [1:0]       out_status
);
  logic q_valid, q_ready;
  job_t q_job;

  rau_front #(.OperandWidth(OPERAND_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  rau_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .out_valid(out_valid), .out_ready(out_ready), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_is_less(out_is_less),
    .out_is_equal(out_is_equal), .out_status(out_status)
  );
endmodule
`default_nettype wire

// ===== verif/rational_arithmetic_unit_tb.sv =====
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic        lt;
    logic        eq;
    logic [1:0]  st;
  } frac_res_t;

  class frac_board;
    frac_res_t pending[$];
    int errors = 0;
    int checked = 0;

    function logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function void note_request(logic [2:0] act, logic [31:0] an_b, logic [30:0] ad_b,
                               logic [31:0] bn_b, logic [30:0] bd_b);
      frac_res_t r;
      longint an, ad, bn, bd, n, d, lv, rv;
      logic [63:0] nm, dm, g;
      bit neg, arith;
      r = '{num: 0, den: 0, lt: 0, eq: 0, st: ST_OK};
      an = longint'(signed'(an_b));
      bn = longint'(signed'(bn_b));
      ad = longint'({1'b0, ad_b});
      bd = longint'({1'b0, bd_b});
      arith = 0;
      n = 0;
      d = 1;
      if (ad == 0 || bd == 0) begin
        r.st = ST_ZDEN;
      end else begin
        case (act)
          ACT_ADD: begin
            n = an * bd + bn * ad; d = ad * bd; arith = 1;
          end
          ACT_SUB: begin
            n = an * bd - bn * ad; d = ad * bd; arith = 1;
          end
          ACT_MUL: begin
            n = an * bn; d = ad * bd; arith = 1;
          end
          ACT_DIV: begin
            if (bn == 0) r.st = ST_DIV0;
            else begin
              n = an * bd; d = ad * bn; arith = 1;
            end
          end
          ACT_CMP: begin
            lv = an * bd;
            rv = bn * ad;
            r.lt = lv < rv;
            r.eq = lv == rv;
          end
          default: ;
        endcase
      end
      if (arith) begin
        neg = (n < 0) != (d < 0);
        nm = n < 0 ? -n : n;
        dm = d < 0 ? -d : d;
        g = euclid(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (nm == 0) neg = 0;
        r.num = neg ? -nm : nm;
        r.den = dm[62:0];
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] num, logic [62:0] den, logic lt, logic eq,
                               logic [1:0] st);
      frac_res_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d st=%0d", $time, signed'(num), den, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (num !== e.num || den !== e.den || lt !== e.lt || eq !== e.eq || st !== e.st) begin
        $display("%0t: mismatch exp %0d/%0d lt=%0b eq=%0b st=%0d got %0d/%0d lt=%0b eq=%0b st=%0d",
                 $time, signed'(e.num), e.den, e.lt, e.eq, e.st,
                 signed'(num), den, lt, eq, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_action = 0;
  logic [31:0] in_a_num = 0;
  logic [30:0] in_a_den = 0;
  logic [31:0] in_b_num = 0;
  logic [30:0] in_b_den = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [63:0] out_res_num;
  logic [62:0] out_res_den;
  logic out_is_less, out_is_equal;
  logic [1:0] out_status;

  frac_board board = new();
  bit stim_done = 0;
  int idle_cycles = 0;
  int sent = 0;
  bit no_gaps = 0;

  localparam int WatchdogLimit = 200000;

  rational_arithmetic_unit dut (.*);

  always #4 clk = ~clk;

  task automatic send_request(logic [2:0] act, logic [31:0] an, logic [30:0] ad,
                              logic [31:0] bn, logic [30:0] bd);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(act, an, ad, bn, bd);
    sent++;
  endtask

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 40) - 32'd20;
      4: return $urandom_range(0, 2000) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 6))
      0: return 31'h7fff_ffff;
      1: return 31'd1;
      2: return 31'($urandom_range(1, 30));
      3: return 31'($urandom_range(1, 5000));
      4: return ($urandom_range(0, 19) == 0) ? 31'd0 : 31'($urandom_range(1, 12));
      default: return 31'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_res_num, out_res_den, out_is_less, out_is_equal, out_status);
  end

  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        w = no_gaps ? 0 : $urandom_range(0, 8);
        if (w > 0) begin
          out_ready <= 0;
          repeat (w) @(posedge clk);
          out_ready <= 1;
        end
      end else if (!out_ready) begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("rational_arithmetic_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] nums[4];
    logic [30:0] dens[3];
    logic [2:0] act;
    logic [31:0] x;
    nums = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff};
    dens = '{31'h7fff_ffff, 1, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (int a = ACT_ADD; a <= 7; a++) begin
      send_request(3'(a), nums[a % 4], dens[a % 2], nums[(a + 1) % 4], dens[(a + 1) % 2]);
    end
    send_request(ACT_DIV, 5, 3, 0, 7);
    send_request(ACT_ADD, 1, 0, 1, 1);
    send_request(ACT_DIV, 1, 1, 0, 0);
    send_request(ACT_CMP, 1, 2, 2, 4);
    send_request(ACT_CMP, 32'h8000_0000, 1, 32'h7fff_ffff, 1);
    send_request(ACT_SUB, 3, 4, 3, 4);
    send_request(ACT_MUL, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_request(ACT_DIV, 32'h8000_0000, 1, 32'h8000_0000, 31'h7fff_ffff);
    send_request(ACT_ADD, 32'h7fff_ffff, 31'h7fff_fffe, 32'h7fff_ffff, 31'h7fff_ffff);
    send_request(ACT_CMP, 32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 1);

    for (int i = 0; i < 700; i++) begin
      no_gaps = (i >= 300 && i < 400);
      if ($urandom_range(0, 19) == 0) act = 3'($urandom_range(5, 7));
      else act = 3'($urandom_range(0, 4));
      x = rand_num();
      if (act == ACT_CMP && $urandom_range(0, 3) == 0)
        send_request(act, x, 3, x, 3);
      else
        send_request(act, x, rand_den(), rand_num(), rand_den());
    end
    in_valid <= 0;
    no_gaps = 0;
    stim_done = 1;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    $display("Sent %0d requests across all actions, checked %0d results", sent, board.checked);
    $display("including zero denominators, divide by zero, extremes and unused codes");
    if (board.errors == 0 && board.pending.size() == 0)
      $display("rational_arithmetic_unit verification clean");
    else
      $display("rational_arithmetic_unit verification failed");
    $finish;
  end
endmodule
